[hdl/hrv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrv_pkg
// shared types and constants of the http request validator
// ----------------------------------------------------------------------------
package hrv_pkg;

  // longest request line, counting its LF
  localparam int MAX_LINE = 1024;
  // line byte counter must hold MAX_LINE + 1
  localparam int LINE_W   = $clog2(MAX_LINE + 2);

  localparam int URI_W    = 11;
  localparam logic [URI_W-1:0] SAT11 = '1;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [23:0] DOTDOT_TAIL = 24'h2F2E2E;

  typedef enum logic [1:0] {
    V_OK     = 2'd0,
    V_BAD    = 2'd1,
    V_NOTIMP = 2'd2
  } verdict_t;

  typedef enum logic [1:0] {
    PH_LINE = 2'd0,
    PH_HEAD = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    HL_START = 2'd0,
    HL_CR    = 2'd1,
    HL_TEXT  = 2'd2
  } hline_t;

  // one received transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } item_t;

  // outcome of one parser step
  typedef struct packed {
    logic             fire;
    verdict_t         verdict;
    logic [URI_W-1:0] uri_length;
  } result_t;

endpackage

[hdl/http_request_validator_core.sv]
// a byte's verdict goes through the input register, then the result register
// throughput: one byte per cycle unless a stalled result is held, set by the parser state update
// a stalled result stops byte intake once the input register also fills
// reset (rst, synchronous, active high) clears all control state; parser starts
// at the request line with no tokens seen
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_validator_core
// http request line validator: GET method, HTTP/1.0 or HTTP/1.1 version, safe URI path,
// header skip up to the blank line, one verdict per connection
// ----------------------------------------------------------------------------
module http_request_validator_core (
  input  logic                     clk,
  input  logic                     rst,
  // byte channel
  input  logic                     data_valid,
  output logic                     data_stall,
  input  logic [7:0]               data_byte,
  input  logic                     stream_end,
  // verdict channel
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic [1:0]               verdict,
  output logic [hrv_pkg::URI_W-1:0] uri_length
);
  import hrv_pkg::*;

  logic    held_valid;
  item_t   held_item;
  result_t step_result;
  logic    advance;

  // the held byte moves through the parser when the result register can
  // take a verdict this cycle (empty, or being drained)
  assign advance = held_valid && (!result_valid || !result_stall);

  // input register
  hrv_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_stall (data_stall),
    .data_byte  (data_byte),
    .stream_end (stream_end),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  // parser state and per-byte update
  hrv_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (held_item),
    .result (step_result)
  );

  // result register
  hrv_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .result       (step_result),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .verdict      (verdict),
    .uri_length   (uri_length)
  );

  // intake only blocks with a full input register
  stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    data_stall |-> held_valid)
    else $error("byte intake stalled with empty input register");

  verdict_code_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> verdict == V_OK || verdict == V_BAD || verdict == V_NOTIMP)
    else $error("undefined verdict code");

  // length is only reported for an accepted request
  length_only_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && verdict != V_OK |-> uri_length == '0)
    else $error("uri length on rejected request");

endmodule

[hdl/hrv_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrv_in_stage
// input register holding one received byte until the parser takes it
// ----------------------------------------------------------------------------
module hrv_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          data_valid,
  output logic          data_stall,
  input  logic [7:0]    data_byte,
  input  logic          stream_end,
  input  logic          advance,
  output logic          held_valid,
  output hrv_pkg::item_t held_item
);
  import hrv_pkg::*;

  logic load;

  // full and not moving on this cycle
  assign data_stall = held_valid && !advance;
  assign load       = data_valid && !data_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_item.data_byte  <= data_byte;
      held_item.stream_end <= stream_end;
    end
  end

endmodule

[hdl/hrv_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrv_parser
// request line tokenizer, checks and header skip, one byte per step
// ----------------------------------------------------------------------------
module hrv_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  hrv_pkg::item_t   item,
  output hrv_pkg::result_t result
);
  import hrv_pkg::*;

  typedef struct packed {
    phase_t             phase;
    logic [2:0]         token_index;
    logic [URI_W-1:0]   token_offset;
    logic               in_gap;
    logic [LINE_W-1:0]  line_bytes;
    logic               method_match;
    logic               version_match;
    logic               uri_leading_slash;
    logic               uri_traversal;
    logic [23:0]        uri_tail;
    logic [URI_W-1:0]   uri_bytes;
    hline_t             header_line_state;
  } pstate_t;

  localparam pstate_t RESET_STATE = '{
    phase: PH_LINE, token_index: 3'd0, token_offset: '0, in_gap: 1'b1,
    line_bytes: '0, method_match: 1'b0, version_match: 1'b0,
    uri_leading_slash: 1'b0, uri_traversal: 1'b0, uri_tail: 24'd0,
    uri_bytes: '0, header_line_state: HL_START
  };

  pstate_t st;
  pstate_t st_next;

  function automatic logic [7:0] get_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h47;  // G
      2'd1:    c = 8'h45;  // E
      default: c = 8'h54;  // T
    endcase
    return c;
  endfunction

  function automatic logic [7:0] ver_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h48;  // H
      3'd1:    c = 8'h54;  // T
      3'd2:    c = 8'h54;  // T
      3'd3:    c = 8'h50;  // P
      3'd4:    c = 8'h2F;  // /
      3'd5:    c = 8'h31;  // 1
      default: c = 8'h2E;  // .
    endcase
    return c;
  endfunction

  // close the token in progress
  function automatic pstate_t end_token(input pstate_t s);
    pstate_t r;
    r = s;
    if (!s.in_gap) begin
      if (s.token_index == 3'd1 && s.token_offset != URI_W'(3)) begin
        r.method_match = 1'b0;
      end
      if (s.token_index == 3'd2 && s.uri_bytes >= URI_W'(3) &&
          s.uri_tail == DOTDOT_TAIL) begin
        r.uri_traversal = 1'b1;
      end
      if (s.token_index == 3'd3 && s.token_offset != URI_W'(8)) begin
        r.version_match = 1'b0;
      end
      r.in_gap = 1'b1;
    end
    return r;
  endfunction

  // fold one non-separator byte into the current token
  function automatic pstate_t token_byte(input pstate_t s, input logic [7:0] b);
    pstate_t r;
    r = s;
    if (s.in_gap) begin
      r.in_gap       = 1'b0;
      r.token_offset = '0;
      if (s.token_index < 3'd4) begin
        r.token_index = s.token_index + 3'd1;
      end
      if (r.token_index == 3'd1) begin
        r.method_match = 1'b1;
      end
      if (r.token_index == 3'd2) begin
        r.uri_tail      = 24'd0;
        r.uri_bytes     = '0;
        r.uri_traversal = 1'b0;
      end
      if (r.token_index == 3'd3) begin
        r.version_match = 1'b1;
      end
    end
    if (r.token_index == 3'd1) begin
      if (r.token_offset >= URI_W'(3) || b != get_char(r.token_offset[1:0])) begin
        r.method_match = 1'b0;
      end
    end else if (r.token_index == 3'd2) begin
      if (r.token_offset == '0) begin
        r.uri_leading_slash = (b == CH_SLASH);
      end
      if (b == CH_SLASH && r.uri_tail == DOTDOT_TAIL) begin
        r.uri_traversal = 1'b1;
      end
      r.uri_tail = {r.uri_tail[15:0], b};
      if (r.uri_bytes != SAT11) begin
        r.uri_bytes = r.uri_bytes + URI_W'(1);
      end
    end else if (r.token_index == 3'd3) begin
      if (r.token_offset < URI_W'(7)) begin
        if (b != ver_char(r.token_offset[2:0])) begin
          r.version_match = 1'b0;
        end
      end else if (r.token_offset == URI_W'(7)) begin
        if (b != 8'h30 && b != 8'h31) begin
          r.version_match = 1'b0;
        end
      end else begin
        r.version_match = 1'b0;
      end
    end
    if (r.token_offset != SAT11) begin
      r.token_offset = r.token_offset + URI_W'(1);
    end
    return r;
  endfunction

  // checks of a finished line, token already closed
  function automatic verdict_t line_check(input pstate_t s);
    verdict_t v;
    if (s.token_index != 3'd3 || !s.method_match || !s.version_match) begin
      v = V_NOTIMP;
    end else if (!s.uri_leading_slash || s.uri_traversal) begin
      v = V_BAD;
    end else begin
      v = V_OK;
    end
    return v;
  endfunction

  always_comb begin
    pstate_t          t;
    verdict_t         v;
    logic [7:0]       b;
    logic [LINE_W-1:0] lb;
    b       = item.data_byte;
    st_next = st;
    result  = '{fire: 1'b0, verdict: V_BAD, uri_length: '0};
    t       = st;
    v       = V_BAD;
    lb      = st.line_bytes + LINE_W'(1);
    if (item.stream_end) begin
      // connection closed: report unless a verdict already went out
      if (st.phase == PH_LINE && st.line_bytes != '0) begin
        t = end_token(st);
        v = line_check(t);
        if (v == V_OK) begin
          v = V_BAD;  // headers never came
        end
      end
      st_next        = RESET_STATE;
      result.fire    = (st.phase != PH_DONE);
      result.verdict = v;
    end else begin
      case (st.phase)
        PH_LINE: begin
          st_next.line_bytes = lb;
          if (lb > LINE_W'(MAX_LINE)) begin
            st_next.phase  = PH_DONE;
            result.fire    = 1'b1;
            result.verdict = V_BAD;
          end else if (b == CH_LF) begin
            t            = end_token(st_next);
            v            = line_check(t);
            st_next      = t;
            if (v != V_OK) begin
              st_next.phase  = PH_DONE;
              result.fire    = 1'b1;
              result.verdict = v;
            end else begin
              st_next.phase             = PH_HEAD;
              st_next.header_line_state = HL_START;
            end
          end else if (b == CH_TAB || b == CH_SPACE || b == CH_CR) begin
            st_next = end_token(st_next);
          end else begin
            st_next = token_byte(st_next, b);
          end
        end
        PH_HEAD: begin
          if (b == CH_LF) begin
            if (st.header_line_state != HL_TEXT) begin
              // blank line ends the header block
              st_next.phase     = PH_DONE;
              result.fire       = 1'b1;
              result.verdict    = V_OK;
              result.uri_length = st.uri_bytes;
            end else begin
              st_next.header_line_state = HL_START;
            end
          end else if (b == CH_CR && st.header_line_state == HL_START) begin
            st_next.header_line_state = HL_CR;
          end else begin
            st_next.header_line_state = HL_TEXT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= RESET_STATE;
    end else if (step) begin
      st <= st_next;
    end
  end

  tok_index_bound: assert property (@(posedge clk) disable iff (rst)
    st.token_index <= 3'd4)
    else $error("token index past saturation");

  end_resets_parser: assert property (@(posedge clk) disable iff (rst)
    step && item.stream_end |=> st.phase == PH_LINE && st.in_gap && st.line_bytes == '0)
    else $error("parser not back at line start after stream end");

  done_no_fire: assert property (@(posedge clk) disable iff (rst)
    step && st.phase == PH_DONE |-> !result.fire)
    else $error("result produced after verdict");

  line_bound: assert property (@(posedge clk) disable iff (rst)
    st.phase == PH_LINE |-> st.line_bytes <= LINE_W'(MAX_LINE))
    else $error("request line counter beyond limit");

endmodule

[hdl/hrv_out_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrv_out_stage
// result register presenting one verdict until the consumer takes it
// ----------------------------------------------------------------------------
module hrv_out_stage (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  hrv_pkg::result_t         result,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic [1:0]               verdict,
  output logic [hrv_pkg::URI_W-1:0] uri_length
);
  import hrv_pkg::*;

  logic load;

  assign load = step && result.fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      verdict    <= result.verdict;
      uri_length <= result.uri_length;
    end
  end

endmodule
